// File: rtl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// shared types, constants and helpers of the relation closure block
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int ROW_W        = 16;
  localparam int IDX_W        = 4;
  localparam int SIZE_W       = 5;
  localparam int CFG_DW       = 32;
  localparam int CFG_AW       = 3;
  localparam int MAX_SIZE_DEF = 16;
  localparam int COL_LIMIT    = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  typedef enum logic {
    REG_SIZE_IN_USE = 1'b0
  } cfg_reg_e;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic [SIZE_W-1:0] size;
  } rcp_entry_t;

  function automatic logic [ROW_W-1:0] col_mask(logic [SIZE_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (SIZE_W'(j) < n);
    end
    return m;
  endfunction

endpackage

// File: rtl/rcp_front.sv
// ----------------------------------------------------------------------------
// rcp_front
// takes relation rows, masks columns, tags row index and end of matrix
// ----------------------------------------------------------------------------
module rcp_front #(
  parameter int MAX_SIZE = rcp_pkg::MAX_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rcp_pkg::ROW_W-1:0]      row_bits_i,
  input  logic [rcp_pkg::SIZE_W-1:0]     size_i,
  input  logic                           full_i,
  output logic                           push_o,
  output rcp_pkg::rcp_entry_t            entry_o
);
  import rcp_pkg::*;

  localparam int LIMIT = (MAX_SIZE < COL_LIMIT) ? MAX_SIZE : COL_LIMIT;

  logic [IDX_W-1:0]  rows_q, rows_d;
  logic [SIZE_W-1:0] n;
  logic              last;

  always_comb begin
    if (size_i == '0) begin
      n = SIZE_W'(1);
    end else if (size_i > SIZE_W'(LIMIT)) begin
      n = SIZE_W'(LIMIT);
    end else begin
      n = size_i;
    end
  end

  assign last       = ({1'b0, rows_q} + SIZE_W'(1)) >= n;
  assign push_o     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  assign entry_o.row  = row_bits_i & col_mask(n);
  assign entry_o.idx  = rows_q;
  assign entry_o.last = last;
  assign entry_o.size = n;

  always_comb begin
    rows_d = rows_q;
    if (push_o) begin
      rows_d = last ? '0 : rows_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else begin
      rows_q <= rows_d;
    end
  end

endmodule

// File: rtl/rcp_fifo.sv
// ----------------------------------------------------------------------------
// rcp_fifo
// two-entry queue of classified rows between front and back
// ----------------------------------------------------------------------------
module rcp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rcp_pkg::rcp_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output rcp_pkg::rcp_entry_t entry_o
);
  import rcp_pkg::*;

  rcp_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/rcp_back.sv
// ----------------------------------------------------------------------------
// rcp_back
// stores rows, runs row-parallel closure steps, checks properties, emits rows
// ----------------------------------------------------------------------------
module rcp_back #(
  parameter int MAX_SIZE = rcp_pkg::MAX_SIZE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  rcp_pkg::rcp_entry_t       entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rcp_pkg::IDX_W-1:0] row_index_o,
  output logic [rcp_pkg::ROW_W-1:0] closure_row_o,
  output logic                      is_reflexive_o,
  output logic                      is_symmetric_o,
  output logic                      is_transitive_o,
  output logic                      last_row_o
);
  import rcp_pkg::*;

  localparam int LIMIT = (MAX_SIZE < COL_LIMIT) ? MAX_SIZE : COL_LIMIT;
  localparam int SW    = $clog2(LIMIT);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INIT,
    ST_STEP,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [SIZE_W-1:0] n_q;
  logic [IDX_W-1:0]  k_q, e_q;
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              refl_q, sym_q, trans_q, out_last_q;

  logic [ROW_W-1:0]  rel_q [LIMIT];
  logic [ROW_W-1:0]  clo_q [LIMIT];
  logic [ROW_W-1:0]  two_q [LIMIT];

  logic [ROW_W-1:0]  rel_k, clo_k;
  logic              k_last, e_last, emit_go;
  logic              refl, sym, trans;

  assign rel_k   = rel_q[k_q[SW-1:0]];
  assign clo_k   = clo_q[k_q[SW-1:0]];
  assign k_last  = ({1'b0, k_q} == n_q - SIZE_W'(1));
  assign e_last  = ({1'b0, e_q} == n_q - SIZE_W'(1));
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign pop_o   = (state_q == ST_LOAD) && valid_i;

  // properties of the loaded relation, two-step rows come from the step loop
  always_comb begin
    refl  = 1'b1;
    sym   = 1'b1;
    trans = 1'b1;
    for (int i = 0; i < LIMIT; i++) begin
      if (SIZE_W'(i) < n_q) begin
        if (!rel_q[i][i]) begin
          refl = 1'b0;
        end
        if ((two_q[i] & ~rel_q[i]) != '0) begin
          trans = 1'b0;
        end
        for (int j = 0; j < LIMIT; j++) begin
          if ((SIZE_W'(j) < n_q) && (rel_q[i][j] != rel_q[j][i])) begin
            sym = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        if (pop_o) begin
          rel_q[entry_i.idx[SW-1:0]] <= entry_i.row;
        end
      end
      ST_INIT: begin
        for (int i = 0; i < LIMIT; i++) begin
          clo_q[i] <= rel_q[i];
          two_q[i] <= '0;
        end
      end
      ST_STEP: begin
        for (int i = 0; i < LIMIT; i++) begin
          if (clo_q[i][k_q]) begin
            clo_q[i] <= clo_q[i] | clo_k;
          end
          if (rel_q[i][k_q]) begin
            two_q[i] <= two_q[i] | rel_k;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          for (int i = 0; i < LIMIT - 1; i++) begin
            clo_q[i] <= clo_q[i+1];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      n_q         <= SIZE_W'(1);
      k_q         <= '0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_row_q   <= '0;
      out_last_q  <= 1'b0;
      refl_q      <= 1'b0;
      sym_q       <= 1'b0;
      trans_q     <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (pop_o && entry_i.last) begin
            n_q     <= entry_i.size;
            k_q     <= '0;
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          if (k_last) begin
            e_q     <= '0;
            state_q <= ST_EMIT;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (e_q == '0) begin
              refl_q  <= refl;
              sym_q   <= sym;
              trans_q <= trans;
            end
            out_idx_q  <= e_q;
            out_row_q  <= clo_q[0] & col_mask(n_q);
            out_last_q <= e_last;
            e_q        <= e_q + IDX_W'(1);
            if (e_last) begin
              state_q <= ST_LOAD;
            end
          end
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign row_index_o     = out_idx_q;
  assign closure_row_o   = out_row_q;
  assign last_row_o      = out_last_q;
  assign is_reflexive_o  = refl_q;
  assign is_symmetric_o  = sym_q;
  assign is_transitive_o = trans_q;

endmodule

// File: rtl/relation_closure_properties_core.sv
// ----------------------------------------------------------------------------
// relation_closure_properties_core
// transitive closure of a boolean relation with reflexive, symmetric and
// transitive checks
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | row_bits_i
//   out     | output    | out_valid_o/out_stall_i | row_index_o, closure_row_o,
//           |           |                       | is_*_o, last_row_o
//   cfg     | input     | psel/penable/pready   | paddr, pwdata, prdata
//
// rows enter one per cycle while in_stall_o is low, through a two-entry queue
// into the row store; after the last row of a matrix the row store is copied,
// then n row-parallel or closure steps run, then the n result rows are
// emitted, each held while out_stall_i is high
// rows of the next matrix queue up while the closure runs, then stall
// reset clears control state only, row stores are undefined until written
// ----------------------------------------------------------------------------
module relation_closure_properties_core #(
  parameter int MAX_SIZE = rcp_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rcp_pkg::ROW_W-1:0]   row_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rcp_pkg::IDX_W-1:0]   row_index_o,
  output logic [rcp_pkg::ROW_W-1:0]   closure_row_o,
  output logic                        is_reflexive_o,
  output logic                        is_symmetric_o,
  output logic                        is_transitive_o,
  output logic                        last_row_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcp_pkg::CFG_AW-1:0]  paddr,
  input  logic [rcp_pkg::CFG_DW-1:0]  pwdata,
  output logic [rcp_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import rcp_pkg::*;

  logic [SIZE_W-1:0] size_q;
  logic              reg_is_size;
  logic              push, full, q_valid, pop;
  rcp_entry_t        push_entry, pop_entry;

  assign pready      = 1'b1;
  assign reg_is_size = (cfg_reg_e'(paddr[CFG_AW-1]) == REG_SIZE_IN_USE);

  always_comb begin
    prdata = '0;
    if (reg_is_size) begin
      prdata = CFG_DW'(size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && reg_is_size) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  rcp_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .row_bits_i (row_bits_i),
    .size_i     (size_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  rcp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (pop_entry)
  );

  rcp_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .entry_i         (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .row_index_o     (row_index_o),
    .closure_row_o   (closure_row_o),
    .is_reflexive_o  (is_reflexive_o),
    .is_symmetric_o  (is_symmetric_o),
    .is_transitive_o (is_transitive_o),
    .last_row_o      (last_row_o)
  );

endmodule
